// ----- src/slmm_pkg.sv -----
// slmm_pkg: shared types and constants for the sorted min/max removal store
// holds the command and status codes, item structs and sizing constants
// no dependencies
package slmm_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned ECNT_W   = 5;

  localparam logic signed [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_TAKE_MIN = 2'd1,
    CMD_TAKE_MAX = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic signed [VAL_W-1:0] in_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    status_e                 status;
    logic [ECNT_W-1:0]       entry_count;
  } out_item_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic                    insert;
    logic                    shift_down;
    logic signed [VAL_W-1:0] value;
  } cell_op_t;

endpackage

// ----- src/slmm_cell.sv -----
// slmm_cell: one slot of the sorted row, holds a single value
// compares against the broadcast value and trades data with its neighbors
// depends on slmm_pkg
module slmm_cell import slmm_pkg::*; (
  input  logic                    clk_i,
  input  cell_op_t                op_i,
  input  logic                    occ_i,
  input  logic                    tail_i,
  input  logic                    left_lt_i,
  input  logic signed [VAL_W-1:0] left_val_i,
  input  logic signed [VAL_W-1:0] right_val_i,
  output logic                    lt_o,
  output logic signed [VAL_W-1:0] val_o
);

  logic signed [VAL_W-1:0] val_q, val_d;

  // new value belongs before this entry, equal values stay ahead
  assign lt_o  = occ_i && (op_i.value < val_q);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (op_i.insert) begin
      if (left_lt_i) begin
        val_d = left_val_i;
      end else if (lt_o || tail_i) begin
        val_d = op_i.value;
      end
    end else if (op_i.shift_down) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ----- src/sorted_list_min_max_removal.sv -----
// sorted_list_min_max_removal: double-ended priority queue kept as a sorted row
// top level, a row of slmm_cell slots, the count and the output register
// depends on slmm_pkg and slmm_cell
//
//   channel | signals                          | item
//   input   | in_valid_i, in_ready_o, in_item_i   | in_item_t (cmd, in_value)
//   output  | out_valid_o, out_ready_i, out_item_o | out_item_t (value, status, count)
//
// all cells compare in parallel, insert and take-min shift the row by one slot,
// the result appears in the output register the cycle after accept
// one command per cycle is sustained while the output side takes items
// reset clears the count and the output valid, cell contents are left as they are
// in_ready_o drops only while a result waits and out_ready_i is low
module sorted_list_min_max_removal import slmm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_m1;
  logic             out_valid_q;
  out_item_t        out_item_q, out_item_d;
  logic             accept, full, empty;
  cell_op_t         op;
  logic [IDX_W-1:0] max_idx;

  logic                    lt   [CAPACITY];
  logic signed [VAL_W-1:0] vals [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (cnt_q == CNT_W'(CAPACITY));
  assign empty      = (cnt_q == '0);
  assign cnt_m1     = cnt_q - CNT_W'(1);
  assign max_idx    = cnt_m1[IDX_W-1:0];

  assign op.insert     = accept && (in_item_i.cmd == CMD_INSERT) && !full;
  assign op.shift_down = accept && (in_item_i.cmd == CMD_TAKE_MIN) && !empty;
  assign op.value      = in_item_i.in_value;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                    left_lt;
    logic signed [VAL_W-1:0] left_val, right_val;

    if (g == 0) begin : g_head
      assign left_lt  = 1'b0;
      assign left_val = vals[0];
    end else begin : g_body
      assign left_lt  = lt[g-1];
      assign left_val = vals[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_val = vals[g];
    end else begin : g_mid
      assign right_val = vals[g+1];
    end

    slmm_cell u_cell (
      .clk_i      (clk_i),
      .op_i       (op),
      .occ_i      (CNT_W'(g) < cnt_q),
      .tail_i     (CNT_W'(g) == cnt_q),
      .left_lt_i  (left_lt),
      .left_val_i (left_val),
      .right_val_i(right_val),
      .lt_o       (lt[g]),
      .val_o      (vals[g])
    );
  end

  always_comb begin
    cnt_d                = cnt_q;
    out_item_d.out_value = in_item_i.in_value;
    out_item_d.status    = ST_OK;
    unique case (in_item_i.cmd)
      CMD_INSERT: begin
        if (full) begin
          out_item_d.status = ST_FULL;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      CMD_TAKE_MIN: begin
        if (empty) begin
          out_item_d.out_value = INT_MIN;
          out_item_d.status    = ST_EMPTY;
        end else begin
          out_item_d.out_value = vals[0];
          cnt_d                = cnt_m1;
        end
      end
      CMD_TAKE_MAX: begin
        if (empty) begin
          out_item_d.out_value = INT_MIN;
          out_item_d.status    = ST_EMPTY;
        end else begin
          out_item_d.out_value = vals[max_idx];
          cnt_d                = cnt_m1;
        end
      end
      CMD_CLEAR: begin
        out_item_d.out_value = '0;
        cnt_d                = '0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
    out_item_d.entry_count = ECNT_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- src/slmm_chk.sv -----
// slmm_chk: port-level checks for sorted_list_min_max_removal
// bound to the top level below, depends on slmm_pkg
module slmm_chk import slmm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  // every accepted item yields a result the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item produced no result");

  a_empty_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_EMPTY |->
      out_item_o.out_value == INT_MIN && out_item_o.entry_count == '0)
    else $error("empty status with wrong value or count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_FULL |->
      out_item_o.entry_count == ECNT_W'(CAPACITY))
    else $error("full status with wrong count");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.cmd == CMD_CLEAR |=>
      out_item_o.entry_count == '0 && out_item_o.status == ST_OK &&
      out_item_o.out_value == '0)
    else $error("clear result wrong");

endmodule

bind sorted_list_min_max_removal slmm_chk u_slmm_chk (.*);
